// File: rtl/core/byte_pattern_matcher_assert.svh
// Assertion macros used by the checker file of the byte pattern matcher.
// The bodies use the clk and rst_n signals of the module that expands them.
`ifndef BYTE_PATTERN_MATCHER_ASSERT_SVH
`define BYTE_PATTERN_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte_pattern_matcher: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte_pattern_matcher: assertion failed");

`endif

// File: rtl/core/bpm_pkg.sv
package bpm_pkg;

  localparam int MAX_NEEDLE_CHARS = 16;
  localparam int WIN_DEPTH        = 2 * MAX_NEEDLE_CHARS;
  localparam int CNT_W            = $clog2(WIN_DEPTH + 1);
  localparam int OFFSET_BITS      = 48;
  localparam int HIT_OFFSET_W     = 48;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_IDX_W        = 3;
  localparam int LEN_W            = 5;
  localparam int REG_CHARS        = 8;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA    = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEEDLE_LOW  = 3'd0,
    REG_NEEDLE_HIGH = 3'd1,
    REG_NEEDLE_LEN  = 3'd2,
    REG_FOLD_CASE   = 3'd3,
    REG_WIDE_MODE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] needle_low;
    logic [CFG_DATA_W-1:0] needle_high;
    logic [LEN_W-1:0]      needle_len;
    logic                  fold_case;
    logic                  wide_mode;
  } cfg_t;

  typedef struct packed {
    logic shift;
    logic fold;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0]     pat_len;
    logic [WIN_DEPTH-1:0] in_use;
  } pat_info_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    if (en && b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
      return b + CASE_DELTA;
    end
    return b;
  endfunction

  // Needle characters past the two registers read as zero bytes.
  function automatic logic [7:0] needle_char(input logic [CFG_DATA_W-1:0] lo,
                                             input logic [CFG_DATA_W-1:0] hi,
                                             input int idx);
    if (idx < REG_CHARS) begin
      return lo[8*idx +: 8];
    end
    if (idx < 2 * REG_CHARS) begin
      return hi[8*(idx-REG_CHARS) +: 8];
    end
    return 8'h00;
  endfunction

endpackage

// File: rtl/core/byte_pattern_matcher.sv
// Streaming needle search over a byte stream.
// Input channel: one byte per transfer (in_data_byte) with in_file_end marking the
// last byte of a file; a transfer happens on a rising edge with in_valid high and
// in_stall low. Output channel: one transfer per hit carrying out_hit_offset, the
// byte offset in the file where the match starts. Hits never overlap.
// Configuration: cfg_wr_en with cfg_index selects needle_chars_low (0),
// needle_chars_high (1), needle_length (2), fold_case (3), wide_mode (4); other
// indexes are ignored. Write only while the block is idle; the window is kept.
// A hit shows on out_valid in the cycle after the transfer of the byte that
// completes it. Throughput: one byte per cycle unless stalled, set by the row
// of 32 compare cells that shift the window and compare all entries in the same
// cycle. The result sits in a single output register; the input side is stalled
// only while that register is full and out_stall is high, so a result that waits
// on a stalled receiver holds back every input byte until it is taken.
// Reset (rst_n low, synchronous) clears the registers, the offset, the match
// window bookkeeping and the output valid. No clearing pass is needed.
module byte_pattern_matcher (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [bpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpm_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_file_end,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bpm_pkg::HIT_OFFSET_W-1:0]   out_hit_offset
);

  localparam int WIN = bpm_pkg::WIN_DEPTH;
  localparam int CW  = bpm_pkg::CNT_W;
  localparam int OW  = bpm_pkg::OFFSET_BITS;

  // Configuration registers.
  bpm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (bpm_pkg::cfg_reg_t'(cfg_index))
        bpm_pkg::REG_NEEDLE_LOW:  cfg_r.needle_low  <= cfg_wr_data;
        bpm_pkg::REG_NEEDLE_HIGH: cfg_r.needle_high <= cfg_wr_data;
        bpm_pkg::REG_NEEDLE_LEN:  cfg_r.needle_len  <= cfg_wr_data[bpm_pkg::LEN_W-1:0];
        bpm_pkg::REG_FOLD_CASE:   cfg_r.fold_case   <= cfg_wr_data[0];
        bpm_pkg::REG_WIDE_MODE:   cfg_r.wide_mode   <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // The pattern is reversed and shifted so that cell j sees the byte it must match.
  logic [WIN-1:0][7:0] pat_bytes;
  bpm_pkg::pat_info_t  pat_info;

  bpm_align u_align (
    .cfg       (cfg_r),
    .pat_bytes (pat_bytes),
    .info      (pat_info)
  );

  // Handshake.
  logic in_xfer;
  logic out_xfer;
  logic out_valid_r;

  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;
  assign out_xfer = out_valid_r & ~out_stall;

  // Row of window cells: cell 0 holds the newest byte.
  bpm_pkg::cell_ctrl_t cell_ctrl;
  logic [WIN-1:0][7:0] win_byte;
  logic [WIN-1:0]      cell_match;

  assign cell_ctrl.shift = in_xfer;
  assign cell_ctrl.fold  = cfg_r.fold_case;

  for (genvar j = 0; j < WIN; j++) begin : g_cell
    bpm_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .byte_in  ((j == 0) ? in_data_byte : win_byte[(j == 0) ? 0 : j - 1]),
      .pat_byte (pat_bytes[j]),
      .byte_out (win_byte[j]),
      .match    (cell_match[j])
    );
  end

  // free_r counts window entries usable by a match: bytes seen since the file
  // began or since the last hit, whichever is later, saturating at the depth.
  logic [CW-1:0] free_r;
  logic [CW-1:0] free_nxt;
  logic [CW-1:0] free_inc;
  logic [OW-1:0] pos_r;
  logic [OW-1:0] pos_nxt;
  logic [OW-1:0] start;
  logic          hit;

  always_comb begin
    free_inc = (free_r == CW'(WIN)) ? free_r : free_r + CW'(1);
    hit      = (pat_info.pat_len != '0) && (pat_info.pat_len <= free_inc) &&
               (&(cell_match | ~pat_info.in_use));
    start    = pos_r - OW'(pat_info.pat_len) + OW'(1);

    free_nxt = free_r;
    pos_nxt  = pos_r;
    if (in_xfer) begin
      free_nxt = (hit || in_file_end) ? '0 : free_inc;
      pos_nxt  = in_file_end ? '0 : pos_r + OW'(1);
    end
  end

  logic [bpm_pkg::HIT_OFFSET_W-1:0] hit_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      free_r <= free_nxt;
      pos_r  <= pos_nxt;
      if (in_xfer && hit) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && hit) begin
      hit_offset_r <= bpm_pkg::HIT_OFFSET_W'(start);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit_offset = hit_offset_r;

endmodule

// File: rtl/core/bpm_cell.sv
module bpm_cell (
  input  logic                clk,
  input  bpm_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          byte_in,
  input  logic [7:0]          pat_byte,
  output logic [7:0]          byte_out,
  output logic                match
);

  logic [7:0] byte_r;

  // The byte arriving now is this cell's window entry once the transfer completes.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign match    = (bpm_pkg::fold_byte(byte_in, ctrl.fold) == pat_byte);

endmodule

// File: rtl/core/bpm_align.sv
module bpm_align (
  input  bpm_pkg::cfg_t                                  cfg,
  output logic [bpm_pkg::WIN_DEPTH-1:0][7:0]             pat_bytes,
  output bpm_pkg::pat_info_t                             info
);

  localparam int VEC_W = 8 * bpm_pkg::WIN_DEPTH;

  logic [bpm_pkg::CNT_W-1:0] chars;
  logic [bpm_pkg::CNT_W-1:0] pat_len;
  logic [bpm_pkg::CNT_W-1:0] shift_bytes;
  logic [VEC_W-1:0]          rev_vec;
  logic [VEC_W-1:0]          aligned_vec;

  always_comb begin
    if (bpm_pkg::CNT_W'(cfg.needle_len) > bpm_pkg::CNT_W'(bpm_pkg::MAX_NEEDLE_CHARS)) begin
      chars = bpm_pkg::CNT_W'(bpm_pkg::MAX_NEEDLE_CHARS);
    end else begin
      chars = bpm_pkg::CNT_W'(cfg.needle_len);
    end
    pat_len     = cfg.wide_mode ? (chars << 1) : chars;
    shift_bytes = bpm_pkg::CNT_W'(bpm_pkg::WIN_DEPTH) - pat_len;
  end

  // Pattern byte i is placed reversed, at byte WIN_DEPTH-1-i of the vector.
  always_comb begin
    logic [7:0] pb;
    for (int i = 0; i < bpm_pkg::WIN_DEPTH; i++) begin
      if (cfg.wide_mode) begin
        pb = (i % 2 == 1) ? 8'h00
                          : bpm_pkg::needle_char(cfg.needle_low, cfg.needle_high, i / 2);
      end else begin
        pb = bpm_pkg::needle_char(cfg.needle_low, cfg.needle_high, i);
      end
      rev_vec[8*(bpm_pkg::WIN_DEPTH-1-i) +: 8] = bpm_pkg::fold_byte(pb, cfg.fold_case);
    end
  end

  // After the shift, window entry j lines up with pattern byte pat_len-1-j.
  assign aligned_vec = rev_vec >> {shift_bytes, 3'b000};

  always_comb begin
    for (int j = 0; j < bpm_pkg::WIN_DEPTH; j++) begin
      pat_bytes[j]   = aligned_vec[8*j +: 8];
      info.in_use[j] = (bpm_pkg::CNT_W'(j) < pat_len);
    end
    info.pat_len = pat_len;
  end

endmodule

// File: rtl/core/bpm_checker.sv
`include "byte_pattern_matcher_assert.svh"

module bpm_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [bpm_pkg::HIT_OFFSET_W-1:0]   out_hit_offset
);

  // A held result keeps its offset.
  `BPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hit_offset))

  // The input is only held back while a result waits on a stalled receiver.
  `BPM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // A new result needs a byte transfer in the cycle before.
  `BPM_ASSERT_NOW(a_result_source, $rose(out_valid), $past(in_valid && !in_stall))

  // A taken result with no new byte leaves the output empty.
  `BPM_ASSERT_NEXT(a_result_once, out_valid && !out_stall && !(in_valid && !in_stall), !out_valid)

endmodule

bind byte_pattern_matcher bpm_checker u_bpm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hit_offset (out_hit_offset)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the streaming needle search. A scoreboard model of the
// matcher runs next to the block: every byte transfer on the input channel is
// pushed through the model, and the model queues the start offset of each hit it
// sees. Every transfer on the result channel is compared against the oldest
// queued offset.
module testbench;

  // Long enough that the single output register fills and the input side stalls.
  localparam int HOLD_CYCLES  = 400;
  // Quiet cycles (no transfer anywhere, no register write) before giving up.
  localparam int QUIET_LIMIT  = 2000;
  // Hits show in the cycle after the byte that completes them, so this drain is
  // plenty before touching the registers or ending the run.
  localparam int DRAIN_CYCLES = 4;
  localparam int REG_COUNT    = 5;
  localparam int PHASES       = 10;
  localparam int PHASE_BYTES  = 110;
  localparam int HOLD_BYTES   = 150;

  localparam logic [7:0] LOWER_A = bpm_pkg::ASCII_UPPER_A + bpm_pkg::CASE_DELTA;
  localparam logic [7:0] LOWER_Z = bpm_pkg::ASCII_UPPER_Z + bpm_pkg::CASE_DELTA;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_wr_en;
  logic [bpm_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [bpm_pkg::CFG_DATA_W-1:0]   cfg_wr_data;
  logic                             in_valid;
  logic                             in_stall;
  logic [7:0]                       in_data_byte;
  logic                             in_file_end;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [bpm_pkg::HIT_OFFSET_W-1:0] out_hit_offset;

  // Scoreboard copy of the registers.
  logic [bpm_pkg::CFG_DATA_W-1:0]   mdl_needle_lo = '0;
  logic [bpm_pkg::CFG_DATA_W-1:0]   mdl_needle_hi = '0;
  logic [bpm_pkg::LEN_W-1:0]        mdl_len = '0;
  logic                             mdl_fold = 1'b0;
  logic                             mdl_wide = 1'b0;

  // Scoreboard copy of the search state. Entry 0 of the window is the newest byte.
  logic [7:0]                       win_bytes [bpm_pkg::WIN_DEPTH] = '{default: 8'h00};
  int                               win_fill = 0;
  int                               win_blocked = 0;
  logic [bpm_pkg::OFFSET_BITS-1:0]  file_pos = '0;

  // Start offsets of hits that the model has seen and the block has not yet sent.
  logic [bpm_pkg::HIT_OFFSET_W-1:0] hit_offsets_due [$];
  logic [bpm_pkg::HIT_OFFSET_W-1:0] due_offset;

  int                               mismatches = 0;
  int                               quiet_cycles = 0;
  int                               burst_left = 0;
  bit                               gaps_on = 1'b0;
  stall_mode_t                      stall_mode = STALL_NONE;
  bit                               hold_request = 1'b0;
  int                               hold_left = 0;
  int                               stall_tick = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_pattern_matcher DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_file_end    (in_file_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit_offset (out_hit_offset)
  );

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if (mdl_fold && c >= bpm_pkg::ASCII_UPPER_A && c <= bpm_pkg::ASCII_UPPER_Z) begin
      return c + bpm_pkg::CASE_DELTA;
    end
    return c;
  endfunction

  // Byte i of the search pattern; in wide mode every odd byte is the zero high
  // byte of a UTF-16LE code unit.
  function automatic logic [7:0] pattern_at(input int i);
    int ci;
    if (mdl_wide && i[0]) begin
      return 8'h00;
    end
    ci = mdl_wide ? i / 2 : i;
    if (ci < bpm_pkg::REG_CHARS) begin
      return mdl_needle_lo[8*ci +: 8];
    end
    return mdl_needle_hi[8*(ci-bpm_pkg::REG_CHARS) +: 8];
  endfunction

  // Pattern length in bytes. Lengths above the needle capacity saturate.
  function automatic int pattern_len();
    int chars;
    chars = (mdl_len > bpm_pkg::MAX_NEEDLE_CHARS) ? bpm_pkg::MAX_NEEDLE_CHARS : int'(mdl_len);
    return mdl_wide ? 2 * chars : chars;
  endfunction

  // Pushes one byte through the model and queues the offset of any hit.
  function automatic void scan_byte(input logic [7:0] d, input logic last);
    int   m;
    int   k;
    logic same;
    logic [bpm_pkg::OFFSET_BITS-1:0] start;
    for (k = bpm_pkg::WIN_DEPTH - 1; k > 0; k--) begin
      win_bytes[k] = win_bytes[k-1];
    end
    win_bytes[0] = d;
    // Once the window is full the oldest entry falls out, and with it one
    // blocked entry if any are left.
    if (win_fill < bpm_pkg::WIN_DEPTH) begin
      win_fill++;
    end else if (win_blocked > 0) begin
      win_blocked--;
    end
    if (win_blocked > win_fill) begin
      win_blocked = win_fill;
    end

    m = pattern_len();
    if (m > 0 && m <= win_fill - win_blocked) begin
      same = 1'b1;
      for (k = 0; k < m; k++) begin
        if (fold_char(win_bytes[m-1-k]) != fold_char(pattern_at(k))) begin
          same = 1'b0;
        end
      end
      if (same) begin
        start = file_pos - bpm_pkg::OFFSET_BITS'(m - 1);
        hit_offsets_due.insert(hit_offsets_due.size(), bpm_pkg::HIT_OFFSET_W'(start));
        // Hits never overlap: everything up to this byte is used up.
        win_blocked = win_fill;
      end
    end

    if (last) begin
      win_bytes   = '{default: 8'h00};
      win_fill    = 0;
      win_blocked = 0;
      file_pos    = '0;
    end else begin
      file_pos = file_pos + 1'b1;
    end
  endfunction

  // Result check and input monitor in one process, so that a byte accepted at
  // this edge is only modeled after this edge's result has been compared.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (hit_offsets_due.size() == 0) begin
          report_mismatch($sformatf("hit at offset %0d with no hit due", out_hit_offset));
        end else begin
          due_offset = hit_offsets_due.pop_front();
          if (out_hit_offset !== due_offset) begin
            report_mismatch($sformatf("hit_offset %0d, model says %0d",
                                      out_hit_offset, due_offset));
          end
        end
      end
      if (in_valid && !in_stall) begin
        scan_byte(in_data_byte, in_file_end);
      end
    end
  end

  // Watchdog on progress: any transfer or register write restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver side. A hold request turns into a long, counted stall; otherwise the
  // stall follows the pattern picked by the current test.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    stall_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 99) < 30);
        STALL_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
        default:        out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // Offers one byte and returns at the edge where its transfer happens. Valid
  // stays high afterwards, so back-to-back bytes never drop it; it only goes low
  // for a gap between bursts or in wait_idle.
  task automatic send_byte(input logic [7:0] d, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = 0;
      if (gaps_on) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_file_end  <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering bytes and waits until every due hit has arrived, plus the
  // latency of a byte that completes no hit.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (hit_offsets_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all five registers, then an index past the last register that the
  // block must ignore. Only called while the block is idle.
  task automatic write_config(input logic [bpm_pkg::CFG_DATA_W-1:0] lo,
                              input logic [bpm_pkg::CFG_DATA_W-1:0] hi,
                              input logic [bpm_pkg::LEN_W-1:0]      len,
                              input logic                           fold,
                              input logic                           wide);
    logic [bpm_pkg::CFG_IDX_W-1:0] spare_index;
    spare_index = bpm_pkg::CFG_IDX_W'($urandom_range(REG_COUNT,
                                                     2 ** bpm_pkg::CFG_IDX_W - 1));
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= bpm_pkg::REG_NEEDLE_LOW;
    cfg_wr_data <= lo;
    @(negedge clk);
    cfg_index   <= bpm_pkg::REG_NEEDLE_HIGH;
    cfg_wr_data <= hi;
    @(negedge clk);
    cfg_index   <= bpm_pkg::REG_NEEDLE_LEN;
    cfg_wr_data <= bpm_pkg::CFG_DATA_W'(len);
    @(negedge clk);
    cfg_index   <= bpm_pkg::REG_FOLD_CASE;
    cfg_wr_data <= bpm_pkg::CFG_DATA_W'(fold);
    @(negedge clk);
    cfg_index   <= bpm_pkg::REG_WIDE_MODE;
    cfg_wr_data <= bpm_pkg::CFG_DATA_W'(wide);
    @(negedge clk);
    cfg_index   <= spare_index;
    cfg_wr_data <= {$urandom, $urandom};
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    mdl_needle_lo = lo;
    mdl_needle_hi = hi;
    mdl_len       = len;
    mdl_fold      = fold;
    mdl_wide      = wide;
  endtask

  // Letters get their case flipped now and then: often with folding on (must
  // still hit), rarely with it off (near misses).
  function automatic logic [7:0] vary_case(input logic [7:0] c);
    logic [7:0] low;
    low = c | bpm_pkg::CASE_DELTA;
    if (low >= LOWER_A && low <= LOWER_Z && $urandom_range(0, 99) < (mdl_fold ? 50 : 5)) begin
      return c ^ bpm_pkg::CASE_DELTA;
    end
    return c;
  endfunction

  function automatic logic [7:0] noise_byte(input int m);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      return vary_case(pattern_at($urandom_range(0, (m > 0) ? m - 1 : 0)));
    end
    if (pick == 4) begin
      return 8'h00;
    end
    if (pick < 7) begin
      return 8'($urandom);
    end
    return (pick == 7 ? bpm_pkg::ASCII_UPPER_A : LOWER_A) + 8'($urandom_range(0, 2));
  endfunction

  task automatic test_empty_needle();
    // Registers are still at reset: length zero, so no byte may hit.
    stall_mode = STALL_NONE;
    gaps_on    = 1'b0;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_fold_no_overlap();
    // Needle "aa" with folding: "AaAaa" hits at 0 and 2; the last 'a' cannot
    // reuse the byte of the second hit.
    wait_idle();
    stall_mode = STALL_RANDOM;
    gaps_on    = 1'b1;
    write_config(bpm_pkg::CFG_DATA_W'({2{LOWER_A}}), '0, bpm_pkg::LEN_W'(2), 1'b1, 1'b0);
    send_byte(bpm_pkg::ASCII_UPPER_A, 1'b0);
    send_byte(LOWER_A, 1'b0);
    send_byte(bpm_pkg::ASCII_UPPER_A, 1'b0);
    send_byte(LOWER_A, 1'b0);
    send_byte(LOWER_A, 1'b1);
  endtask

  task automatic test_wide_case_exact();
    // Wide needle "Z" is the two bytes 'Z', 0. Without folding "z\0" must miss.
    wait_idle();
    write_config(bpm_pkg::CFG_DATA_W'(bpm_pkg::ASCII_UPPER_Z), '0, bpm_pkg::LEN_W'(1),
                 1'b0, 1'b1);
    send_byte(bpm_pkg::ASCII_UPPER_Z, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(LOWER_Z, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_length_saturation();
    int k;
    // A length above the capacity acts as sixteen characters, so the high
    // register takes part.
    wait_idle();
    write_config('1, '1, '1, 1'b0, 1'b0);
    for (k = 0; k < bpm_pkg::MAX_NEEDLE_CHARS; k++) begin
      send_byte(8'hFF, k == bpm_pkg::MAX_NEEDLE_CHARS - 1);
    end
  endtask

  task automatic test_file_boundary();
    // A match split across two files must not hit.
    wait_idle();
    write_config(bpm_pkg::CFG_DATA_W'({LOWER_A + 8'd1, LOWER_A}), '0, bpm_pkg::LEN_W'(2),
                 1'b0, 1'b0);
    send_byte(LOWER_A, 1'b1);
    send_byte(LOWER_A + 8'd1, 1'b1);
  endtask

  // Each phase picks a needle and mode, then streams files in which copies of
  // the pattern (some with one byte corrupted) are mixed into noise made mostly
  // of needle bytes, so partial and overlapping matches are common.
  task automatic test_random_phases();
    logic [7:0]                     chars [bpm_pkg::MAX_NEEDLE_CHARS];
    logic [bpm_pkg::CFG_DATA_W-1:0] lo;
    logic [bpm_pkg::CFG_DATA_W-1:0] hi;
    logic [bpm_pkg::LEN_W-1:0]      len;
    logic                           fold;
    logic                           wide;
    logic [7:0]                     file_bytes [$];
    int phase;
    int flen;
    int m;
    int sent;
    int k;
    int bad;
    for (phase = 0; phase < PHASES; phase++) begin
      for (k = 0; k < bpm_pkg::MAX_NEEDLE_CHARS; k++) begin
        if (phase == 4) begin
          chars[k] = 8'hFF;
        end else if (phase == 5) begin
          chars[k] = 8'h00;
        end else if ($urandom_range(0, 9) < 7) begin
          chars[k] = ($urandom_range(0, 1) ? bpm_pkg::ASCII_UPPER_A : LOWER_A)
                     + 8'($urandom_range(0, 2));
        end else begin
          chars[k] = 8'($urandom);
        end
      end
      for (k = 0; k < bpm_pkg::REG_CHARS; k++) begin
        lo[8*k +: 8] = chars[k];
        hi[8*k +: 8] = chars[k+bpm_pkg::REG_CHARS];
      end
      case (phase)
        0:       len = bpm_pkg::LEN_W'(bpm_pkg::MAX_NEEDLE_CHARS);
        1:       len = bpm_pkg::LEN_W'(1);
        2:       len = '0;
        3:       len = bpm_pkg::LEN_W'($urandom_range(bpm_pkg::MAX_NEEDLE_CHARS + 1,
                                                      2 ** bpm_pkg::LEN_W - 1));
        6:       len = bpm_pkg::LEN_W'(bpm_pkg::MAX_NEEDLE_CHARS);
        default: len = bpm_pkg::LEN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                                    : $urandom_range(1, 5));
      endcase
      // Phase 0 is the longest pattern: wide, sixteen characters, the whole window.
      fold = (phase == 0) ? 1'b1 : 1'($urandom);
      wide = (phase == 0) ? 1'b1 : (phase == 1 || phase == 6) ? 1'b0 : 1'($urandom);

      wait_idle();
      write_config(lo, hi, len, fold, wide);
      stall_mode = stall_mode_t'(phase % 4);
      gaps_on    = (phase % 3 != 2);
      m          = pattern_len();
      sent       = 0;
      while (sent < PHASE_BYTES) begin
        flen = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 60) : $urandom_range(61, 300);
        file_bytes.delete();
        while (file_bytes.size() < flen) begin
          if (m > 0 && $urandom_range(0, 99) < 35) begin
            bad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, m - 1) : -1;
            for (k = 0; k < m; k++) begin
              file_bytes.insert(file_bytes.size(),
                                (k == bad) ? 8'($urandom) : vary_case(pattern_at(k)));
            end
          end else begin
            file_bytes.insert(file_bytes.size(), noise_byte(m));
          end
        end
        for (k = 0; k < file_bytes.size(); k++) begin
          send_byte(file_bytes[k], k == file_bytes.size() - 1);
        end
        sent += file_bytes.size();
      end
    end
  endtask

  task automatic test_output_hold();
    int k;
    // "ab" repeated hits every second byte. The receiver holds off for a long
    // stretch while bytes keep coming, so the output register fills and the
    // block has to stall its input.
    wait_idle();
    write_config(bpm_pkg::CFG_DATA_W'({LOWER_A + 8'd1, LOWER_A}), '0, bpm_pkg::LEN_W'(2),
                 1'b0, 1'b0);
    stall_mode   = STALL_NONE;
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    for (k = 0; k < HOLD_BYTES; k++) begin
      send_byte(k[0] ? LOWER_A + 8'd1 : LOWER_A, k == HOLD_BYTES - 1);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = bpm_pkg::REG_NEEDLE_LOW;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    in_file_end  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_needle();
    test_fold_no_overlap();
    test_wide_case_exact();
    test_length_saturation();
    test_file_boundary();
    test_random_phases();
    test_output_hold();

    wait_idle();
    if (hit_offsets_due.size() != 0) begin
      report_mismatch($sformatf("%0d hits never arrived", hit_offsets_due.size()));
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: byte_pattern_matcher.f
+incdir+rtl/core
rtl/core/bpm_pkg.sv
rtl/core/bpm_cell.sv
rtl/core/bpm_align.sv
rtl/core/byte_pattern_matcher.sv
rtl/core/bpm_checker.sv
tb/testbench.sv
